>>> sv/sspp_pkg.sv
package sspp_pkg;

   // Frame limits
   localparam int HUNT_LIMIT  = 64;
   localparam int MAX_LENGTH  = 32;
   localparam int MIN_LENGTH  = 2;
   localparam int MAX_RESULTS = 30;

   // Derived widths
   localparam int HUNT_W      = $clog2(HUNT_LIMIT + 1);
   localparam int LEN_W       = $clog2(MAX_LENGTH + 1);
   localparam int STORE_DEPTH = MAX_LENGTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Fixed field widths
   localparam int BYTE_W    = 8;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 5;
   localparam int TICK_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_KEEP_LIMIT    = 1'b1;
   localparam logic [TICK_W-1:0]    TIMEOUT_RESET     = 16'd50;
   localparam logic [COUNT_W-1:0]   KEEP_LIMIT_RESET  = 5'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_START = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_TICK  = 2'd2
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_TIMEOUT  = 2'd1,
      STAT_HUNT_OVF = 2'd2,
      STAT_BAD_LEN  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HUNT,
      PH_ID,
      PH_LEN,
      PH_BODY
   } phase_type;

   typedef enum logic [1:0] {
      SQ_ACCEPT,
      SQ_READ,
      SQ_EMIT
   } seq_state_type;

endpackage

>>> sv/sspp_if.sv
interface sspp_req_if;
   logic                              valid;
   logic                              ready;
   logic [sspp_pkg::CMD_W-1:0]        command;
   logic [sspp_pkg::BYTE_W-1:0]       rx_byte;

   modport source (output valid, command, rx_byte, input ready);
   modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface sspp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sspp_pkg::STATUS_W-1:0]     status;
   logic [sspp_pkg::BYTE_W-1:0]       servo_id;
   logic [sspp_pkg::BYTE_W-1:0]       error_code;
   logic [sspp_pkg::COUNT_W-1:0]      kept_count;
   logic [sspp_pkg::COUNT_W-1:0]      param_index;
   logic [sspp_pkg::BYTE_W-1:0]       param_byte;
   logic                              last;

   modport source (output valid, status, servo_id, error_code, kept_count,
                   param_index, param_byte, last, input ready);
   modport sink   (input valid, status, servo_id, error_code, kept_count,
                   param_index, param_byte, last, output ready);
endinterface

interface sspp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sspp_pkg::CSR_IDX_W-1:0]    index;
   logic [sspp_pkg::CSR_DAT_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/sspp_ram.sv
module sspp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> sv/servo_status_packet_parser_unit.sv
// Status packet receiver for a half-duplex servo bus. Send a start transfer to arm it,
// then one transfer per received bus byte and one per time tick. The parser hunts for
// two 0xFF header bytes (overflow status after 64 bytes), takes the id and the length
// (2..32 accepted, else invalid-length status), then the error byte, the parameter bytes
// and the checksum byte, which is consumed but not checked. The tick that brings the
// count since start up to timeout_ticks abandons reception with timeout status. A
// failure gives one result transfer with status and last set, all other fields zero. A good
// frame gives one result per kept parameter (at most keep_limit, at most 30), or a
// single result with zero count if none are kept; last marks the final one. Every
// request transfer is taken while no results are pending; the request that closes a frame
// or fails it then holds the request side while results drain.
// Parameters sit in a 32-entry RAM with registered read, and a single index
// incrementer walks it: each parameter result takes a RAM read state, then an output
// state that holds while the output stalls; a frame with no kept parameter or a failing
// request goes straight to the output state.
module servo_status_packet_parser_unit (
   input  logic            clock,
   input  logic            reset,
   sspp_req_if.sink        req_bus,
   sspp_rsp_if.source      rsp_bus,
   sspp_csr_if.sink        csr_bus
);

   // Configuration registers
   logic [sspp_pkg::TICK_W-1:0]  timeout_ff;
   logic [sspp_pkg::COUNT_W-1:0] keep_limit_ff;

   // Parser state
   sspp_pkg::phase_type           phase_ff, phase_in;
   logic [sspp_pkg::BYTE_W-1:0]   prev_byte_ff, prev_byte_in;
   logic [sspp_pkg::HUNT_W-1:0]   hunt_ff, hunt_in;
   logic [sspp_pkg::TICK_W-1:0]   elapsed_ff, elapsed_in;
   logic [sspp_pkg::BYTE_W-1:0]   frame_id_ff, frame_id_in;
   logic [sspp_pkg::LEN_W-1:0]    length_ff, length_in;
   logic [sspp_pkg::LEN_W-1:0]    body_ff, body_in;
   logic [sspp_pkg::BYTE_W-1:0]   err_byte_ff, err_byte_in;

   // Result sequencer
   sspp_pkg::seq_state_type       seq_ff, seq_in;
   sspp_pkg::status_type          status_ff, status_in;
   logic [sspp_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [sspp_pkg::COUNT_W-1:0]  idx_ff, idx_in;

   // Parameter store
   logic                          wr_en;
   logic [sspp_pkg::ADDR_W-1:0]   wr_addr;
   logic                          rd_en;
   logic [sspp_pkg::BYTE_W-1:0]   rd_data;

   // Scratch
   logic [sspp_pkg::HUNT_W-1:0]   hunt_next;
   logic [sspp_pkg::TICK_W-1:0]   elapsed_next;
   logic [sspp_pkg::LEN_W-1:0]    body_next;
   logic [sspp_pkg::LEN_W-1:0]    kept;
   logic                          rsp_last;

   sspp_ram #(
      .WIDTH(sspp_pkg::BYTE_W),
      .DEPTH(sspp_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_bus.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[sspp_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Configuration writes land immediately; the port never stalls.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= sspp_pkg::TIMEOUT_RESET;
         keep_limit_ff <= sspp_pkg::KEEP_LIMIT_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            sspp_pkg::REG_TIMEOUT_TICKS: timeout_ff <= csr_bus.data;
            sspp_pkg::REG_KEEP_LIMIT: begin
               keep_limit_ff <= csr_bus.data[sspp_pkg::COUNT_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // Request side is open only while no results are pending.
   assign req_bus.ready = (seq_ff == sspp_pkg::SQ_ACCEPT);

   // Result payload: failure results carry only the status and last.
   assign rsp_last            = (count_ff == '0) ||
                                ((idx_ff + sspp_pkg::COUNT_W'(1)) == count_ff);
   assign rsp_bus.valid       = (seq_ff == sspp_pkg::SQ_EMIT);
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.servo_id    = (status_ff == sspp_pkg::STAT_OK) ? frame_id_ff : '0;
   assign rsp_bus.error_code  = (status_ff == sspp_pkg::STAT_OK) ? err_byte_ff : '0;
   assign rsp_bus.kept_count  = count_ff;
   assign rsp_bus.param_index = idx_ff;
   assign rsp_bus.param_byte  = (count_ff == '0) ? '0 : rd_data;
   assign rsp_bus.last        = rsp_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= sspp_pkg::PH_IDLE;
         seq_ff    <= sspp_pkg::SQ_ACCEPT;
         hunt_ff   <= '0;
         body_ff   <= '0;
         elapsed_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         seq_ff    <= seq_in;
         hunt_ff   <= hunt_in;
         body_ff   <= body_in;
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_byte_ff <= prev_byte_in;
      frame_id_ff  <= frame_id_in;
      length_ff    <= length_in;
      err_byte_ff  <= err_byte_in;
      status_ff    <= status_in;
      count_ff     <= count_in;
      idx_ff       <= idx_in;
   end

   always_comb begin
      phase_in     = phase_ff;
      prev_byte_in = prev_byte_ff;
      hunt_in      = hunt_ff;
      elapsed_in   = elapsed_ff;
      frame_id_in  = frame_id_ff;
      length_in    = length_ff;
      body_in      = body_ff;
      err_byte_in  = err_byte_ff;
      seq_in       = seq_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      rd_en        = 1'b0;

      hunt_next    = hunt_ff + sspp_pkg::HUNT_W'(1);
      body_next    = body_ff + sspp_pkg::LEN_W'(1);
      elapsed_next = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + sspp_pkg::TICK_W'(1);

      // Kept parameters: length minus two, limited by keep_limit and the result cap.
      kept = length_ff - sspp_pkg::LEN_W'(sspp_pkg::MIN_LENGTH);
      if (kept > sspp_pkg::LEN_W'(keep_limit_ff)) begin
         kept = sspp_pkg::LEN_W'(keep_limit_ff);
      end
      if (kept > sspp_pkg::LEN_W'(sspp_pkg::MAX_RESULTS)) begin
         kept = sspp_pkg::LEN_W'(sspp_pkg::MAX_RESULTS);
      end

      case (seq_ff)
         sspp_pkg::SQ_ACCEPT: begin
            if (req_bus.valid) begin
               case (req_bus.command)
                  sspp_pkg::CMD_START: begin
                     // Rearm; a start mid-frame restarts silently.
                     phase_in     = sspp_pkg::PH_HUNT;
                     prev_byte_in = '0;
                     hunt_in      = '0;
                     elapsed_in   = '0;
                     frame_id_in  = '0;
                     length_in    = '0;
                     body_in      = '0;
                     err_byte_in  = '0;
                  end
                  sspp_pkg::CMD_BYTE: begin
                     case (phase_ff)
                        sspp_pkg::PH_HUNT: begin
                           hunt_in = hunt_next;
                           if (hunt_next >= sspp_pkg::HUNT_W'(2) &&
                               prev_byte_ff == sspp_pkg::HEADER_BYTE &&
                               req_bus.rx_byte == sspp_pkg::HEADER_BYTE) begin
                              phase_in = sspp_pkg::PH_ID;
                           end else begin
                              prev_byte_in = req_bus.rx_byte;
                              if (hunt_next >= sspp_pkg::HUNT_W'(sspp_pkg::HUNT_LIMIT)) begin
                                 phase_in  = sspp_pkg::PH_IDLE;
                                 status_in = sspp_pkg::STAT_HUNT_OVF;
                                 count_in  = '0;
                                 idx_in    = '0;
                                 seq_in    = sspp_pkg::SQ_EMIT;
                              end
                           end
                        end
                        sspp_pkg::PH_ID: begin
                           frame_id_in = req_bus.rx_byte;
                           phase_in    = sspp_pkg::PH_LEN;
                        end
                        sspp_pkg::PH_LEN: begin
                           if (req_bus.rx_byte < sspp_pkg::BYTE_W'(sspp_pkg::MIN_LENGTH) ||
                               req_bus.rx_byte > sspp_pkg::BYTE_W'(sspp_pkg::MAX_LENGTH)) begin
                              phase_in  = sspp_pkg::PH_IDLE;
                              status_in = sspp_pkg::STAT_BAD_LEN;
                              count_in  = '0;
                              idx_in    = '0;
                              seq_in    = sspp_pkg::SQ_EMIT;
                           end else begin
                              length_in = req_bus.rx_byte[sspp_pkg::LEN_W-1:0];
                              body_in   = '0;
                              phase_in  = sspp_pkg::PH_BODY;
                           end
                        end
                        sspp_pkg::PH_BODY: begin
                           // First body byte is the error byte, then parameters,
                           // then the checksum, which is dropped.
                           if (body_ff == '0) begin
                              err_byte_in = req_bus.rx_byte;
                           end else if (body_next < length_ff) begin
                              wr_en   = 1'b1;
                              wr_addr = sspp_pkg::ADDR_W'(body_ff - sspp_pkg::LEN_W'(1));
                           end
                           body_in = body_next;
                           if (body_next >= length_ff) begin
                              phase_in  = sspp_pkg::PH_IDLE;
                              status_in = sspp_pkg::STAT_OK;
                              count_in  = sspp_pkg::COUNT_W'(kept);
                              idx_in    = '0;
                              seq_in    = (kept == '0) ? sspp_pkg::SQ_EMIT : sspp_pkg::SQ_READ;
                           end
                        end
                        default: ;
                     endcase
                  end
                  sspp_pkg::CMD_TICK: begin
                     if (phase_ff != sspp_pkg::PH_IDLE) begin
                        elapsed_in = elapsed_next;
                        if (elapsed_next >= timeout_ff) begin
                           phase_in  = sspp_pkg::PH_IDLE;
                           status_in = sspp_pkg::STAT_TIMEOUT;
                           count_in  = '0;
                           idx_in    = '0;
                           seq_in    = sspp_pkg::SQ_EMIT;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         sspp_pkg::SQ_READ: begin
            // Fetch the parameter at the current index.
            rd_en  = 1'b1;
            seq_in = sspp_pkg::SQ_EMIT;
         end
         sspp_pkg::SQ_EMIT: begin
            // Hold the result until the transfer completes, then advance.
            if (rsp_bus.ready) begin
               if (rsp_last) begin
                  seq_in = sspp_pkg::SQ_ACCEPT;
               end else begin
                  idx_in = idx_ff + sspp_pkg::COUNT_W'(1);
                  seq_in = sspp_pkg::SQ_READ;
               end
            end
         end
         default: seq_in = sspp_pkg::SQ_ACCEPT;
      endcase
   end

endmodule
